// ===== hdl/rsp_pkg.sv =====
// Package for the run-length sprite decoder with palette.
// Holds the shared widths, codes and structs; depends on nothing else.
package rsp_pkg;

	localparam int DIM_W = 11;
	localparam int LEN_W = 20;
	localparam int IDX_W = 20;
	localparam int ROW_W = 11;
	localparam int COL_W = 12;
	localparam int RUN_W = 8;
	localparam int BYTE_W = 8;
	localparam int LVL_W = 6;
	localparam int COLOR_W = 3 * LVL_W;
	localparam int ARGB_W = 32;
	localparam int PAL_ENTRIES = 256;
	localparam int PAL_ADDR_W = 8;
	localparam int OP_W = 2;
	localparam int REG_IDX_W = 2;

	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 56;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam logic [7:0] ALPHA_FF = 8'hFF;

	// Item kinds
	localparam logic [OP_W-1:0] OP_PAL_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
	localparam logic [OP_W-1:0] OP_DATA = 2'd2;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PAYLOAD = 2'd2;

	typedef enum logic [2:0] {
		PH_FINISHED,
		PH_ROW_HEAD,
		PH_SKIP,
		PH_COUNT,
		PH_PIXELS,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [LEN_W-1:0] payload_len;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [PAL_ADDR_W-1:0] slot;
		logic [LVL_W-1:0] red;
		logic [LVL_W-1:0] green;
		logic [LVL_W-1:0] blue;
		logic [BYTE_W-1:0] code;
	} in_item_t;

	// One decoded result on its way from the decoder to the output stage
	typedef struct packed {
		logic pix;
		logic done;
		logic [IDX_W-1:0] base;
		logic [COL_W-1:0] col;
		logic [COLOR_W-1:0] color;
	} cmd_t;

endpackage

// ===== hdl/rle_sprite_palette_decoder.sv =====
// Run-length sprite decoder with a 256-entry palette, top level.
// Three register stages: the result stage, the queue and the output register.
// Throughput: one input transaction per cycle; s_tready falls only when the result stage and
// the queue hold four results between them, with a fifth in the output register, behind a stalled sink.
// Reset clears configuration to its defaults and all control state; palette contents
// stay undefined until written, with no clearing pass.
module rle_sprite_palette_decoder #(
	parameter int MAX_WIDTH = rsp_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rsp_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rsp_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [rsp_pkg::LEN_W-1:0]      cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// palette_slot, red_level, green_level, blue_level, code_byte, zero pad
	input  logic [rsp_pkg::IN_DATA_W-1:0]  s_tdata,
	// op
	input  logic [rsp_pkg::OP_W-1:0]       s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// pixel_index, pixel_argb, zero pad
	output logic [rsp_pkg::OUT_DATA_W-1:0] m_tdata,
	// pixel_valid
	output logic [0:0]                     m_tuser,
	// image_done
	output logic                           m_tlast
);
	import rsp_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic [LEN_W-1:0] payload_len_q;
	cfg_t cfg;
	in_item_t item;
	logic in_accept;
	logic cmd_valid;
	cmd_t cmd;
	logic q_pop, q_not_empty;
	cmd_t q_head;
	logic [QCNT_W-1:0] q_count;
	logic [QCNT_W:0] in_flight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_W'(1);
			height_q <= DIM_W'(1);
			payload_len_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WIDTH: width_q <= cfg_wdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_wdata[DIM_W-1:0];
				REG_PAYLOAD: payload_len_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = '{width: width_q, height: height_q, payload_len: payload_len_q};
	assign item = '{op: s_tuser, slot: s_tdata[7:0], red: s_tdata[13:8],
		green: s_tdata[19:14], blue: s_tdata[25:20], code: s_tdata[33:26]};

	// Room is reserved for the result that may still sit in the decoder's result stage.
	assign in_flight = {1'b0, q_count} + {{QCNT_W{1'b0}}, cmd_valid};
	assign s_tready = (in_flight < (QCNT_W+1)'(QUEUE_DEPTH));
	assign in_accept = s_tvalid && s_tready;

	rsp_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_accept(in_accept),
		.item     (item),
		.cmd_valid(cmd_valid),
		.cmd      (cmd)
	);

	rsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_valid),
		.push_data(cmd),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (q_head),
		.count    (q_count)
	);

	rsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_not_empty),
		.head      (q_head),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> q_count < QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_plain_result_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast)
		else $error("result without pixel and without image end");

	a_plain_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("result without pixel carries nonzero data");

endmodule

// ===== hdl/rsp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module rsp_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/rsp_front.sv =====
// Front part of the sprite decoder: the row and run state machine, the palette RAM
// and the result stage. Depends on rsp_pkg and rsp_ram.
module rsp_front #(
	parameter int MAX_WIDTH = rsp_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rsp_pkg::MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rsp_pkg::cfg_t     cfg,
	input  logic              in_accept,
	input  rsp_pkg::in_item_t item,
	output logic              cmd_valid,
	output rsp_pkg::cmd_t     cmd
);
	import rsp_pkg::*;

	phase_t phase_q, phase_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [RUN_W-1:0] rbc_q, rbc_d;
	logic [RUN_W-1:0] rbu_q, rbu_d;
	logic [RUN_W-1:0] run_q, run_d;
	logic [LEN_W-1:0] pos_q, pos_d;

	logic valid_s1, pix_s1, done_s1;
	logic [IDX_W-1:0] base_s1;
	logic [COL_W-1:0] col_s1;

	logic [DIM_W-1:0] w_eff, h_eff;
	logic [COL_W-1:0] w_col;
	logic [2*DIM_W-1:0] row_prod;
	logic [COLOR_W-1:0] pal_rdata;

	logic pix, done, stop_req, next_req, run_end;
	logic [LEN_W+1:0] stop_p1;
	logic [COL_W-1:0] col_sum;

	assign w_eff = (int'(cfg.width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg.width;
	assign h_eff = (int'(cfg.height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : cfg.height;
	assign w_col = {{(COL_W-DIM_W){1'b0}}, w_eff};
	assign row_prod = {{(2*DIM_W-ROW_W){1'b0}}, row_q} * {{DIM_W{1'b0}}, w_eff};

	rsp_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PAL_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (in_accept && item.op == OP_PAL_WRITE),
		.waddr(item.slot),
		.wdata({item.red, item.green, item.blue}),
		.raddr(item.code),
		.rdata(pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FINISHED;
			row_q <= '0;
			col_q <= '0;
			rbc_q <= '0;
			rbu_q <= '0;
			run_q <= '0;
			pos_q <= '0;
		end else begin
			phase_q <= phase_d;
			row_q <= row_d;
			col_q <= col_d;
			rbc_q <= rbc_d;
			rbu_q <= rbu_d;
			run_q <= run_d;
			pos_q <= pos_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		row_d = row_q;
		col_d = col_q;
		rbc_d = rbc_q;
		rbu_d = rbu_q;
		run_d = run_q;
		pos_d = pos_q;
		pix = 1'b0;
		done = 1'b0;
		stop_req = 1'b0;
		next_req = 1'b0;
		run_end = 1'b0;
		stop_p1 = '0;
		col_sum = '0;
		if (in_accept) begin
			case (item.op)
				OP_BEGIN: begin
					row_d = '0;
					col_d = '0;
					rbc_d = '0;
					rbu_d = '0;
					run_d = '0;
					pos_d = '0;
					if (h_eff == '0) begin
						phase_d = PH_FINISHED;
						done = 1'b1;
					end else begin
						phase_d = PH_ROW_HEAD;
					end
				end
				OP_DATA: begin
					if (phase_q != PH_FINISHED) begin
						pos_d = pos_q + LEN_W'(1);
						if (phase_q == PH_ROW_HEAD) begin
							if (item.code == '0) begin
								next_req = 1'b1;
							end else begin
								rbc_d = item.code;
								rbu_d = '0;
								col_d = '0;
								phase_d = PH_SKIP;
							end
						end else begin
							rbu_d = rbu_q + RUN_W'(1);
							case (phase_q)
								PH_DRAIN: begin
									if (rbu_d >= rbc_q) begin
										next_req = 1'b1;
									end
								end
								PH_SKIP: begin
									col_sum = col_q + {{(COL_W-BYTE_W){1'b0}}, item.code};
									col_d = col_sum;
									if (col_sum >= w_col) begin
										stop_req = 1'b1;
										stop_p1 = {2'b00, pos_q} + (LEN_W+2)'(1);
									end else begin
										phase_d = PH_COUNT;
									end
								end
								PH_COUNT: begin
									run_d = item.code;
									if (item.code == '0) begin
										run_end = 1'b1;
									end else begin
										phase_d = PH_PIXELS;
									end
								end
								PH_PIXELS: begin
									pix = (col_q < w_col);
									col_d = col_q + COL_W'(1);
									run_d = run_q - RUN_W'(1);
									run_end = (run_d == '0);
								end
								default: begin
								end
							endcase
							if (run_end) begin
								if (col_d >= w_col ||
								    ({1'b0, rbu_d} + 9'd1) >= {1'b0, rbc_q}) begin
									stop_req = 1'b1;
									stop_p1 = {2'b00, pos_q} + (LEN_W+2)'(2);
								end else begin
									phase_d = PH_SKIP;
								end
							end
							// Row byte count used up without an earlier stop.
							if (phase_q != PH_DRAIN && !stop_req && rbu_d >= rbc_q) begin
								stop_req = 1'b1;
								stop_p1 = {2'b00, pos_q} + (LEN_W+2)'(2);
							end
						end
					end
				end
				default: begin
				end
			endcase
			if (stop_req) begin
				if (stop_p1 >= {2'b00, cfg.payload_len}) begin
					phase_d = PH_FINISHED;
					done = 1'b1;
				end else if (rbu_d >= rbc_d) begin
					next_req = 1'b1;
				end else begin
					phase_d = PH_DRAIN;
				end
			end
			if (next_req) begin
				row_d = row_q + ROW_W'(1);
				col_d = '0;
				if (row_d >= h_eff) begin
					phase_d = PH_FINISHED;
					done = 1'b1;
				end else begin
					phase_d = PH_ROW_HEAD;
				end
			end
		end
	end

	// Result stage; the palette read for the same byte lands alongside it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pix_s1 <= 1'b0;
			done_s1 <= 1'b0;
		end else begin
			valid_s1 <= pix || done;
			pix_s1 <= pix;
			done_s1 <= done;
		end
	end

	always_ff @(posedge clk) begin
		base_s1 <= row_prod[IDX_W-1:0];
		col_s1 <= col_q;
	end

	assign cmd_valid = valid_s1;
	assign cmd = '{pix: pix_s1, done: done_s1, base: base_s1, col: col_s1,
		color: pix_s1 ? pal_rdata : '0};

	a_begin_starts_row: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && item.op == OP_BEGIN && h_eff != '0 |=> phase_q == PH_ROW_HEAD)
		else $error("begin transaction did not open the first row");

	a_idle_byte_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && item.op == OP_DATA && phase_q == PH_FINISHED |=> !valid_s1)
		else $error("byte after the end of the image produced a result");

	a_palette_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && item.op == OP_PAL_WRITE |=> !valid_s1)
		else $error("palette write produced a result");

endmodule

// ===== hdl/rsp_queue.sv =====
// Short result queue between the decoder and the output stage.
// Depends on rsp_pkg.
module rsp_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  rsp_pkg::cmd_t              push_data,
	input  logic                       pop,
	output logic                       not_empty,
	output rsp_pkg::cmd_t              head,
	output logic [rsp_pkg::QCNT_W-1:0] count
);
	import rsp_pkg::*;

	cmd_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign not_empty = (count_q != '0);
	assign head = entry_q[rd_ptr_q];
	assign count = count_q;

endmodule

// ===== hdl/rsp_back.sv =====
// Output stage: forms pixel index and ARGB colour and holds the result for the sink.
// Depends on rsp_pkg.
module rsp_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_valid,
	input  rsp_pkg::cmd_t                  head,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rsp_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [0:0]                     m_tuser,
	output logic                           m_tlast
);
	import rsp_pkg::*;

	logic valid_q, pix_q, done_q;
	logic [IDX_W-1:0] index_q;
	logic [ARGB_W-1:0] argb_q;
	logic [LVL_W-1:0] red, green, blue;

	assign pop = head_valid && (!valid_q || m_tready);
	assign {red, green, blue} = head.color;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pix_q <= head.pix;
			done_q <= head.done;
			if (head.pix) begin
				index_q <= head.base + {{(IDX_W-COL_W){1'b0}}, head.col};
				argb_q <= {ALPHA_FF, red, 2'b00, green, 2'b00, blue, 2'b00};
			end else begin
				index_q <= '0;
				argb_q <= '0;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {{(OUT_DATA_W-ARGB_W-IDX_W){1'b0}}, argb_q, index_q};
	assign m_tuser = pix_q;
	assign m_tlast = done_q;

endmodule

// ===== tb/rsp_pixel_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the run-length sprite decoder: watches the configuration port
// and both stream channels, predicts every pixel result and compares it in order.
// Depends on rsp_pkg only.
module rsp_pixel_checker #(
	parameter int MAX_WIDTH = rsp_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rsp_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rsp_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [rsp_pkg::LEN_W-1:0]      cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [rsp_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [rsp_pkg::OP_W-1:0]       s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [rsp_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [0:0]                     m_tuser,
	input  logic                           m_tlast,
	output int                             mismatches,
	output int                             outstanding
);
	import rsp_pkg::*;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0]  index;
		logic [ARGB_W-1:0] argb;
		logic             done;
	} pixel_result_t;

	pixel_result_t pending_pixels[$];

	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic [LEN_W-1:0] payload_reg;

	// Colors are kept already scaled by four, as 0xRRGGBB.
	logic [23:0] palette [PAL_ENTRIES];

	phase_t            phase;
	logic [ROW_W-1:0]  row_num;
	logic [COL_W-1:0]  column;
	logic [BYTE_W-1:0] row_len;
	logic [BYTE_W-1:0] row_used;
	logic [RUN_W-1:0]  run_left;
	logic [LEN_W-1:0]  byte_pos;

	function automatic int unsigned eff_width();
		return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
	endfunction

	// Moves on to the next row; returns 1 when that was the last row.
	function automatic bit advance_row();
		row_num = row_num + 1'b1;
		column = '0;
		if (row_num >= eff_height()) begin
			phase = PH_FINISHED;
			return 1'b1;
		end
		phase = PH_ROW_HEAD;
		return 1'b0;
	endfunction

	// Decoding of the current row stopped with the stream at position p.
	function automatic bit end_row(int unsigned p);
		if (p + 1 >= payload_reg) begin
			phase = PH_FINISHED;
			return 1'b1;
		end
		if (row_used >= row_len)
			return advance_row();
		phase = PH_DRAIN;
		return 1'b0;
	endfunction

	task automatic decode_item(input logic [OP_W-1:0] op, input logic [IN_DATA_W-1:0] d);
		logic [PAL_ADDR_W-1:0] slot;
		logic [LVL_W-1:0]      red, green, blue;
		logic [BYTE_W-1:0]     code;
		int unsigned           w, pos;
		logic [31:0]           linear;
		bit                    stopped, run_end;
		pixel_result_t         res;
		slot = d[7:0];
		red = d[13:8];
		green = d[19:14];
		blue = d[25:20];
		code = d[33:26];
		w = eff_width();
		res = '0;
		stopped = 1'b0;
		run_end = 1'b0;
		case (op)
			OP_PAL_WRITE: begin
				palette[slot] = {red, 2'b00, green, 2'b00, blue, 2'b00};
			end
			OP_BEGIN: begin
				row_num = '0;
				column = '0;
				row_len = '0;
				row_used = '0;
				run_left = '0;
				byte_pos = '0;
				if (eff_height() == 0) begin
					phase = PH_FINISHED;
					res.done = 1'b1;
				end else begin
					phase = PH_ROW_HEAD;
				end
			end
			OP_DATA: begin
				if (phase != PH_FINISHED) begin
					pos = byte_pos;
					byte_pos = byte_pos + 1'b1;
					if (phase == PH_ROW_HEAD) begin
						if (code == 0) begin
							res.done = advance_row();
						end else begin
							row_len = code;
							row_used = '0;
							column = '0;
							phase = PH_SKIP;
						end
					end else begin
						row_used = row_used + 1'b1;
						if (phase == PH_DRAIN) begin
							if (row_used >= row_len)
								res.done = advance_row();
							stopped = 1'b1;
						end else if (phase == PH_SKIP) begin
							column = column + code;
							if (column >= w) begin
								res.done = end_row(pos);
								stopped = 1'b1;
							end else begin
								phase = PH_COUNT;
							end
						end else begin
							if (phase == PH_COUNT) begin
								run_left = code;
								if (code == 0)
									run_end = 1'b1;
								else
									phase = PH_PIXELS;
							end else begin
								// Pixels past the width still use up their bytes.
								if (column < w) begin
									linear = row_num * w + column;
									res.valid = 1'b1;
									res.index = linear[IDX_W-1:0];
									res.argb = {ALPHA_FF, palette[code]};
								end
								column = column + 1'b1;
								run_left = run_left - 1'b1;
								if (run_left == 0)
									run_end = 1'b1;
							end
							if (run_end) begin
								if (column >= w ||
										int'(row_used) + 1 >= int'(row_len)) begin
									res.done = end_row(pos + 1);
									stopped = 1'b1;
								end else begin
									phase = PH_SKIP;
								end
							end
						end
						if (!stopped && row_used >= row_len)
							res.done = end_row(pos + 1);
					end
				end
			end
			default: ;
		endcase
		if (res.valid || res.done)
			pending_pixels.push_back(res);
	endtask

	task automatic note_mismatch(input string what, input pixel_result_t exp,
			input pixel_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t ns: %s", $realtime, what);
			$display("  expected valid=%0d index=%05h argb=%08h done=%0d",
				exp.valid, exp.index, exp.argb, exp.done);
			$display("  got      valid=%0d index=%05h argb=%08h done=%0d",
				got.valid, got.index, got.argb, got.done);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t got;
		pixel_result_t exp;
		if (!arst_n) begin
			width_reg = 1;
			height_reg = 1;
			payload_reg = '0;
			foreach (palette[i])
				palette[i] = '0;
			phase = PH_FINISHED;
			row_num = '0;
			column = '0;
			row_len = '0;
			row_used = '0;
			run_left = '0;
			byte_pos = '0;
			pending_pixels.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// A result accepted now was caused by an earlier transaction, so compare first.
			if (m_tvalid && m_tready) begin
				got = {m_tuser[0], m_tdata[IDX_W-1:0], m_tdata[IDX_W +: ARGB_W], m_tlast};
				if (pending_pixels.size() == 0) begin
					note_mismatch("unexpected result", '0, got);
				end else begin
					exp = pending_pixels.pop_front();
					if (got.valid !== exp.valid || got.index !== exp.index ||
							got.argb !== exp.argb || got.done !== exp.done)
						note_mismatch("wrong result", exp, got);
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_WIDTH: width_reg = cfg_wdata[DIM_W-1:0];
					REG_HEIGHT: height_reg = cfg_wdata[DIM_W-1:0];
					REG_PAYLOAD: payload_reg = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				decode_item(s_tuser, s_tdata);
			outstanding = pending_pixels.size();
		end
	end

endmodule

// ===== tb/tb_rle_sprite_palette_decoder.sv =====
`timescale 1ns / 100ps
// Top of the sprite decoder testbench: clock, reset, configuration phases and
// stream stimulus; checking is done by rsp_pixel_checker. Depends on rsp_pkg.
module tb_rle_sprite_palette_decoder;
	import rsp_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int NUM_PHASES = 12;
	localparam int MAX_LEN = 20'hFFFFF;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [LEN_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;
	logic                  m_tlast;

	int mismatches;
	int outstanding;
	int quiet_cycles = 0;
	int items_sent = 0;
	bit stall_free = 1'b0;

	rle_sprite_palette_decoder dut (.*);

	rsp_pixel_checker u_checker (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(negedge clk)
		m_tready <= stall_free || ($urandom_range(99) >= 11);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic push(input logic [OP_W-1:0] op, input logic [IN_DATA_W-1:0] data);
		while (!stall_free && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	// The fields a code byte does not use carry random bits.
	task automatic send_code(input logic [BYTE_W-1:0] code);
		push(OP_DATA, {6'b0, code, 26'($urandom)});
	endtask

	task automatic send_color(input int slot, input int red, input int green, input int blue);
		push(OP_PAL_WRITE, {6'b0, 8'($urandom), 6'(blue), 6'(green), 6'(red), 8'(slot)});
	endtask

	task automatic write_regs(input int w, input int h, input int len);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_wdata <= LEN_W'(w);
		@(negedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_wdata <= LEN_W'(h);
		@(negedge clk);
		cfg_index <= REG_PAYLOAD;
		cfg_wdata <= LEN_W'(len);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Lets the decoder run dry, including items that leave no result behind.
	task automatic settle();
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_row(input int w);
		logic [BYTE_W-1:0] body[$];
		int pairs, skip, run, len;
		if ($urandom_range(99) < 8) begin
			send_code(8'd0);
			return;
		end
		pairs = $urandom_range(3, 1);
		repeat (pairs) begin
			skip = ($urandom_range(3) == 0) ? $urandom_range(255)
				: $urandom_range((w < 6) ? w : 6);
			run = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(8);
			body.push_back(BYTE_W'(skip));
			body.push_back(BYTE_W'(run));
			repeat (run)
				body.push_back(BYTE_W'($urandom_range(255)));
		end
		while (body.size() > 255)
			void'(body.pop_back());
		len = body.size();
		// A wrong byte count makes the rest of the row land where a count is due, or the next bytes fall into this row.
		if ($urandom_range(99) < 10)
			len = $urandom_range(255, 1);
		send_code(BYTE_W'(len));
		foreach (body[i])
			send_code(body[i]);
	endtask

	task automatic send_image(input int w, input int h);
		int rows;
		push(OP_BEGIN, IN_DATA_W'({$urandom, $urandom}));
		rows = (h > 6) ? $urandom_range(4, 1) : h;
		for (int r = 0; r < rows; r++) begin
			if ($urandom_range(99) < 4) begin
				if ($urandom_range(1) == 0)
					push(OP_UNUSED, IN_DATA_W'({$urandom, $urandom}));
				else
					send_color($urandom_range(255), $urandom_range(63),
						$urandom_range(63), $urandom_range(63));
			end
			// Now and then the next begin cuts the image short.
			if ($urandom_range(99) < 3)
				break;
			send_row(w);
		end
		if ($urandom_range(4) == 0)
			send_code(BYTE_W'($urandom_range(255)));
	endtask

	initial begin
		int w, h, len, target;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_regs(8, 4, 1000);
		// Every palette entry is written before any pixel can read it.
		send_color(0, 0, 0, 0);
		for (int i = 1; i < 255; i++)
			send_color(i, $urandom_range(63), $urandom_range(63), $urandom_range(63));
		send_color(255, 63, 63, 63);

		// Directed image, 8 wide and 4 rows high.
		push(OP_BEGIN, '0);
		// Row of two pairs, the second run empty and ending the row.
		send_code(8'd7);
		send_code(8'd0);
		send_code(8'd3);
		send_code(8'd0);
		send_code(8'd255);
		send_code(8'd17);
		send_code(8'd1);
		send_code(8'd0);
		// A palette write while decoding takes effect at once.
		send_color(17, 63, 0, 42);
		// A run that crosses the right edge: the last two pixels are dropped.
		send_code(8'd5);
		send_code(8'd7);
		send_code(8'd3);
		send_code(8'd17);
		send_code(8'd200);
		send_code(8'd9);
		// A skip past the width; the rest of the row is drained.
		send_code(8'd4);
		send_code(8'd9);
		send_code(8'd1);
		send_code(8'd2);
		send_code(8'd3);
		// Empty last row ends the image.
		send_code(8'd0);
		// Neither a byte after the end nor an unused kind does anything.
		send_code(8'hAA);
		push(OP_UNUSED, '1);

		for (int k = 0; k < NUM_PHASES; k++) begin
			case (k)
				0: begin w = 1; h = 1; len = MAX_LEN; end
				1: begin w = 1024; h = 2; len = MAX_LEN; end
				2: begin w = 2047; h = 2047; len = MAX_LEN; end
				3: begin w = 5; h = 0; len = MAX_LEN; end
				4: begin w = 8; h = 3; len = 0; end
				5: begin w = $urandom_range(16, 4); h = 4; len = $urandom_range(60, 10); end
				default: begin
					w = $urandom_range(24, 1);
					h = $urandom_range(6, 1);
					len = ($urandom_range(3) == 0) ? $urandom_range(300, 20) : MAX_LEN;
				end
			endcase
			settle();
			write_regs(w, h, len);
			stall_free = (k == 6 || k == 7);
			target = items_sent + RANDOM_ITEMS / NUM_PHASES;
			while (items_sent < target)
				send_image((w > 1024) ? 1024 : w, (h > 1024) ? 1024 : h);
		end

		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
